FILE: sv/mtlc_pkg.sv
// Shared definitions for the inverter torque commander.
// Holds opcodes, frame identifiers, arithmetic constants and the job record
// passed from the front end to the back end. No dependencies.
package mtlc_pkg;

   localparam logic [2:0] OP_STORE   = 3'd0;
   localparam logic [2:0] OP_PEDAL   = 3'd1;
   localparam logic [2:0] OP_DIRECT  = 3'd2;
   localparam logic [2:0] OP_ENABLE  = 3'd3;
   localparam logic [2:0] OP_DISABLE = 3'd4;

   localparam logic [10:0] ID_VOLTAGE = 11'h0A7;
   localparam logic [10:0] ID_SPEED   = 11'h0A5;

   localparam logic CSR_AMP_PEAK    = 1'b0;
   localparam logic CSR_TORQUE_CEIL = 1'b1;

   localparam logic [7:0]  AMP_PEAK_RESET    = 8'd60;
   localparam logic [11:0] TORQUE_CEIL_RESET = 12'd230;

   // Pi in Q30; speeds below this many rpm are under 15 rad/s.
   localparam logic [31:0]        PI_Q30         = 32'd3373259426;
   localparam logic signed [15:0] SLOW_RPM_LIMIT = 16'sd144;

   localparam logic [12:0] VOLT_OFFSET    = 13'd4050;
   localparam logic signed [16:0] VOLT_FLOOR = 17'sd4150;
   localparam logic [11:0] CURRENT_FLOOR  = 12'd100;
   localparam logic [13:0] POWER_SCALE    = 14'd12000;
   localparam int          QUOT_BITS      = 18;
   localparam logic [15:0] TORQUE_SAT     = 16'd32767;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic               direct;
      logic               enable;
      logic [12:0]        pedal;
      logic [15:0]        torque;
      logic signed [15:0] voltage;
      logic signed [15:0] speed;
   } job_type;

endpackage

FILE: sv/mtlc_front.sv
// Front end of the torque commander: accepts input transfers, keeps the
// frame state and enable bit, and queues torque jobs. Uses mtlc_pkg.
module mtlc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_opcode,
   input  logic [10:0]         req_frame_id,
   input  logic signed [15:0]  req_rx_word_low,
   input  logic signed [15:0]  req_rx_word_high,
   input  logic [12:0]         req_pedal_position,
   input  logic [15:0]         req_torque_value,
   input  logic                q_full,
   output logic                q_push,
   output mtlc_pkg::job_type   q_entry
);
   import mtlc_pkg::*;

   logic signed [15:0] voltage_ff, voltage_in;
   logic signed [15:0] speed_ff, speed_in;
   logic               enable_ff, enable_in;
   logic               accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      voltage_in = voltage_ff;
      speed_in   = speed_ff;
      enable_in  = enable_ff;
      q_push     = 1'b0;
      if (accept) begin
         case (req_opcode)
            OP_STORE: begin
               if (req_frame_id == ID_VOLTAGE) begin
                  voltage_in = req_rx_word_low;
               end else if (req_frame_id == ID_SPEED) begin
                  speed_in = req_rx_word_high;
               end
            end
            OP_PEDAL, OP_DIRECT: q_push = 1'b1;
            OP_ENABLE:  enable_in = 1'b1;
            OP_DISABLE: enable_in = 1'b0;
            default: ;
         endcase
      end
   end

   assign q_entry.direct  = (req_opcode == OP_DIRECT);
   assign q_entry.enable  = enable_ff;
   assign q_entry.pedal   = req_pedal_position;
   assign q_entry.torque  = req_torque_value;
   assign q_entry.voltage = voltage_ff;
   assign q_entry.speed   = speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_ff <= '0;
         speed_ff   <= '0;
         enable_ff  <= 1'b0;
      end else begin
         voltage_ff <= voltage_in;
         speed_ff   <= speed_in;
         enable_ff  <= enable_in;
      end
   end

endmodule

FILE: sv/mtlc_queue.sv
// Short job queue between the front end and the back end.
// Register-based circular buffer of job records. Uses mtlc_pkg.
module mtlc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mtlc_pkg::job_type  push_data,
   input  logic               pop,
   output mtlc_pkg::job_type  pop_data,
   output logic               full,
   output logic               not_empty
);
   import mtlc_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_IDX_W:0]   count_ff, count_in;

   assign full      = (count_ff == (QUEUE_IDX_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/mtlc_back.sv
// Back end of the torque commander: derates the pedal torque with a serial
// divider and holds the result register. Uses mtlc_pkg.
module mtlc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  mtlc_pkg::job_type  q_entry,
   output logic               q_pop,
   input  logic [7:0]         amp_peak,
   input  logic [11:0]        torque_ceil,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_torque_command,
   output logic               rsp_enable_flag
);
   import mtlc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   job_type              job_ff;
   logic [24:0]          prod_ff;
   logic [24:0]          cur_ff;
   logic [46:0]          den_ff;
   logic                 slow_ff;
   logic [16:0]          cmd_ff;
   logic [46:0]          rem_ff;
   logic [QUOT_BITS-1:0] quot_ff;
   logic [4:0]           count_ff;
   logic                 rsp_valid_ff;
   logic signed [15:0]   rsp_torque_ff;
   logic                 rsp_enable_ff;

   logic signed [16:0] volt_ext;
   logic signed [16:0] volt_limit;
   logic [11:0]        i10;
   logic [47:0]        rem_shift;
   logic               rem_ge;
   logic [17:0]        limited;
   logic [15:0]        result;
   logic               out_free;

   assign volt_ext   = {job_ff.voltage[15], job_ff.voltage};
   assign volt_limit = $signed({4'b0000, VOLT_OFFSET + 13'(amp_peak) * 13'd10});

   always_comb begin
      if (volt_ext > volt_limit) begin
         i10 = 12'(amp_peak) * 12'd10;
      end else if (volt_ext <= VOLT_FLOOR) begin
         i10 = CURRENT_FLOOR;
      end else begin
         i10 = 12'(volt_ext - $signed({4'b0000, VOLT_OFFSET}));
      end
   end

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      if (slow_ff || ({1'b0, cmd_ff} < quot_ff)) begin
         limited = {1'b0, cmd_ff};
      end else begin
         limited = quot_ff;
      end
      if (job_ff.direct) begin
         result = job_ff.torque;
      end else if (limited > 18'(TORQUE_SAT)) begin
         result = TORQUE_SAT;
      end else begin
         result = limited[15:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_not_empty;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               state_in = q_entry.direct ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_SCALE;
         ST_SCALE: state_in = slow_ff ? ST_DONE : ST_DIV;
         ST_DIV: begin
            if (count_ff == 5'(QUOT_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_entry;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= 25'(job_ff.pedal) * 25'(torque_ceil);
         cur_ff  <= 25'(job_ff.pedal) * 25'(i10);
         den_ff  <= 47'(job_ff.speed[14:0]) * 47'(PI_Q30);
         slow_ff <= (job_ff.speed < SLOW_RPM_LIMIT);
      end
      if (state_ff == ST_SCALE) begin
         cmd_ff   <= 17'((29'(prod_ff) * 29'd10) >> 12);
         rem_ff   <= 47'(39'(cur_ff) * 39'(POWER_SCALE));
         quot_ff  <= '0;
         count_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         rem_ff   <= rem_ge ? 47'(rem_shift - {1'b0, den_ff}) : rem_shift[46:0];
         quot_ff  <= {quot_ff[QUOT_BITS-2:0], rem_ge};
         count_ff <= count_ff + 1'b1;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_torque_ff <= result;
         rsp_enable_ff <= job_ff.enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_torque_command = rsp_torque_ff;
   assign rsp_enable_flag    = rsp_enable_ff;

   a_div_only_fast: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (!slow_ff && !job_ff.direct))
      else $error("divider running on a slow or direct job");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished job did not reach the result register");

endmodule

FILE: sv/motor_torque_limit_command_unit.sv
// Top level of the inverter torque commander: configuration registers, front
// end, job queue and back end. Uses mtlc_pkg, mtlc_front, mtlc_queue, mtlc_back.
//
// Frame-store, enable and disable transfers give no result; torque requests
// are queued two deep, so the input keeps taking transfers while a result
// waits, until the queue is full. A direct torque request goes from the queue
// straight to the done state and the result register; a pedal request at or
// above 144 rpm passes the multiply, scale and 18-step serial divider states
// of the back end, and a slower one skips the divider.
module motor_torque_limit_command_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic [10:0]        req_frame_id,
   input  logic signed [15:0] req_rx_word_low,
   input  logic signed [15:0] req_rx_word_high,
   input  logic [12:0]        req_pedal_position,
   input  logic [15:0]        req_torque_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_torque_command,
   output logic               rsp_enable_flag,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [11:0]        csr_wdata
);
   import mtlc_pkg::*;

   logic [7:0]  amp_peak_ff;
   logic [11:0] torque_ceil_ff;
   logic        q_full;
   logic        q_push;
   logic        q_pop;
   logic        q_not_empty;
   job_type     push_entry;
   job_type     pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_peak_ff    <= AMP_PEAK_RESET;
         torque_ceil_ff <= TORQUE_CEIL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AMP_PEAK:    amp_peak_ff    <= csr_wdata[7:0];
            CSR_TORQUE_CEIL: torque_ceil_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mtlc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_frame_id       (req_frame_id),
      .req_rx_word_low    (req_rx_word_low),
      .req_rx_word_high   (req_rx_word_high),
      .req_pedal_position (req_pedal_position),
      .req_torque_value   (req_torque_value),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (push_entry)
   );

   mtlc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_entry),
      .pop       (q_pop),
      .pop_data  (pop_entry),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   mtlc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_entry            (pop_entry),
      .q_pop              (q_pop),
      .amp_peak           (amp_peak_ff),
      .torque_ceil        (torque_ceil_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_torque_command (rsp_torque_command),
      .rsp_enable_flag    (rsp_enable_flag)
   );

endmodule
